[rtl/spi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spi_pkg;

  localparam int COORD_W = 32;
  localparam int RGB_W   = 24;
  localparam int TAG_W   = 16;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int MAX_Y_W = 31;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RGB_W-1:0]          rgb;
    logic [TAG_W-1:0]          tag;
  } point_t;

endpackage

`default_nettype wire

[rtl/spi_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface spi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [spi_pkg::MODE_W-1:0]           mode;
  logic signed [spi_pkg::COORD_W-1:0]   x_value;
  logic signed [spi_pkg::COORD_W-1:0]   y_value;
  logic [spi_pkg::RGB_W-1:0]            point_color;
  logic [spi_pkg::TAG_W-1:0]            name_tag;
  logic [spi_pkg::INDEX_W-1:0]          read_index;

  modport source (
    output valid, mode, x_value, y_value, point_color, name_tag, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, x_value, y_value, point_color, name_tag, read_index,
    output ready
  );
endinterface

`default_nettype wire

[rtl/spi_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface spi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 point_valid;
  logic signed [spi_pkg::COORD_W-1:0]   point_x;
  logic signed [spi_pkg::COORD_W-1:0]   point_y;
  logic [spi_pkg::RGB_W-1:0]            point_rgb;
  logic [spi_pkg::TAG_W-1:0]            point_tag;
  logic [spi_pkg::COUNT_W-1:0]          entry_count;
  logic signed [spi_pkg::COORD_W-1:0]   min_x;
  logic signed [spi_pkg::COORD_W-1:0]   max_x;
  logic signed [spi_pkg::COORD_W-1:0]   min_y;
  logic [spi_pkg::MAX_Y_W-1:0]          max_y;
  logic                                 insert_dropped;

  modport source (
    output valid, point_valid, point_x, point_y, point_rgb, point_tag, entry_count,
           min_x, max_x, min_y, max_y, insert_dropped,
    input  ready
  );
  modport sink (
    input  valid, point_valid, point_x, point_y, point_rgb, point_tag, entry_count,
           min_x, max_x, min_y, max_y, insert_dropped,
    output ready
  );
endinterface

`default_nettype wire

[rtl/spi_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module spi_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 7
) (
  input  wire logic                         clk,
  input  wire logic                         insert,
  input  wire spi_pkg::point_t              new_point,
  input  wire logic [COUNT_W-1:0]           count,
  input  wire logic                         gt_in,
  input  wire spi_pkg::point_t              prev_point,
  output logic                              gt_out,
  output spi_pkg::point_t                   point,
  input  wire logic [spi_pkg::INDEX_W-1:0]  read_idx,
  input  wire spi_pkg::point_t              rd_in,
  output spi_pkg::point_t                   rd_out
);

  logic live;
  logic at_end;
  logic hit;

  assign live   = (32'(count) > INDEX);
  assign at_end = (32'(count) == INDEX);
  assign gt_out = live && (point.x > new_point.x);
  assign hit    = (32'(read_idx) == INDEX);

  // shift right when the left neighbor also holds a larger key
  always_ff @(posedge clk) begin
    if (insert) begin
      if (gt_in) begin
        point <= prev_point;
      end else if (gt_out || at_end) begin
        point <= new_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_out <= hit ? point : rd_in;
  end

endmodule

`default_nettype wire

[rtl/sorted_point_insert_table_unit.sv]
// Keeps up to TABLE_DEPTH points (Q16.16 x and y, 24-bit color, 16-bit tag) sorted by x in a
// row of cells; a new point lands before the first stored x that is strictly greater, so equal
// keys keep arrival order. Items are taken one at a time: ready drops at acceptance and comes
// back the cycle after the result is taken. Insert, clear and the unused mode go from
// acceptance through the load state to the output state. A read walks the row first, and
// the selected entry is picked up by a read word that moves one cell per cycle along the row.
// Every result also reports count, min/max x, min y and max y (floored at 0), all zero when the
// table is empty; an insert into a full table is dropped and flagged. Entries are never
// cleared, only the count and the y bounds are.
`timescale 1ns / 1ps
`default_nettype none

module sorted_point_insert_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  spi_in_if.sink   req,
  spi_out_if.source rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = $clog2(TABLE_DEPTH);

  spi_pkg::state_t state, state_next;

  logic [CW-1:0]                         count;
  logic signed [spi_pkg::COORD_W-1:0]    min_y;
  logic [spi_pkg::MAX_Y_W-1:0]           max_y;
  logic signed [spi_pkg::COORD_W-1:0]    last_x;
  logic [spi_pkg::INDEX_W-1:0]           rd_idx;
  logic                                  dropped;
  logic [WW-1:0]                         walk_cnt;

  logic                                  accept;
  logic                                  full;
  logic                                  do_insert;
  logic                                  is_read;
  spi_pkg::mode_t                        mode;
  spi_pkg::point_t                       new_point;

  logic                                  gt   [TABLE_DEPTH];
  spi_pkg::point_t                       ent  [TABLE_DEPTH];
  spi_pkg::point_t                       rd   [TABLE_DEPTH];

  logic                                  o_valid;
  logic                                  o_point_valid;
  spi_pkg::point_t                       o_point;
  logic [spi_pkg::COUNT_W-1:0]           o_count;
  logic signed [spi_pkg::COORD_W-1:0]    o_min_x;
  logic signed [spi_pkg::COORD_W-1:0]    o_max_x;
  logic signed [spi_pkg::COORD_W-1:0]    o_min_y;
  logic [spi_pkg::MAX_Y_W-1:0]           o_max_y;
  logic                                  o_dropped;
  logic                                  o_is_read;
  logic                                  hit_valid;

  assign mode      = spi_pkg::mode_t'(req.mode);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign do_insert = accept && (mode == spi_pkg::MODE_INSERT) && !full;
  assign is_read   = (mode == spi_pkg::MODE_READ);

  assign new_point.x   = req.x_value;
  assign new_point.y   = req.y_value;
  assign new_point.rgb = req.point_color;
  assign new_point.tag = req.name_tag;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spi_cell #(.INDEX(i), .COUNT_W(CW)) u_cell (
        .clk        (clk),
        .insert     (do_insert),
        .new_point  (new_point),
        .count      (count),
        .gt_in      (1'b0),
        .prev_point (new_point),
        .gt_out     (gt[i]),
        .point      (ent[i]),
        .read_idx   (rd_idx),
        .rd_in      ('0),
        .rd_out     (rd[i])
      );
    end else begin : g_body
      spi_cell #(.INDEX(i), .COUNT_W(CW)) u_cell (
        .clk        (clk),
        .insert     (do_insert),
        .new_point  (new_point),
        .count      (count),
        .gt_in      (gt[i-1]),
        .prev_point (ent[i-1]),
        .gt_out     (gt[i]),
        .point      (ent[i]),
        .read_idx   (rd_idx),
        .rd_in      (rd[i-1]),
        .rd_out     (rd[i])
      );
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spi_pkg::ST_IDLE;
      count    <= '0;
      min_y    <= '0;
      max_y    <= '0;
      walk_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == spi_pkg::ST_WALK) begin
        walk_cnt <= walk_cnt + WW'(1);
      end else begin
        walk_cnt <= '0;
      end
      if (do_insert) begin
        count <= count + CW'(1);
        if ((count == '0) || (min_y > req.y_value)) begin
          min_y <= req.y_value;
        end
        if (!req.y_value[spi_pkg::COORD_W-1] &&
            (req.y_value[spi_pkg::MAX_Y_W-1:0] > max_y)) begin
          max_y <= req.y_value[spi_pkg::MAX_Y_W-1:0];
        end
      end else if (accept && (mode == spi_pkg::MODE_CLEAR)) begin
        count <= '0;
        min_y <= '0;
        max_y <= '0;
      end
    end
  end

  // item context and largest key
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx  <= (is_read) ? req.read_index : '0;
      dropped <= (mode == spi_pkg::MODE_INSERT) && full;
    end
    if (do_insert && ((count == '0) || !(last_x > req.x_value))) begin
      last_x <= req.x_value;
    end
  end

  assign hit_valid = (32'(rd_idx) < 32'(count));

  // result register
  always_ff @(posedge clk) begin
    if (state == spi_pkg::ST_LOAD) begin
      o_count   <= spi_pkg::COUNT_W'(32'(count));
      o_dropped <= dropped;
      if (count != '0) begin
        o_min_x <= ent[0].x;
        o_max_x <= last_x;
        o_min_y <= min_y;
        o_max_y <= max_y;
      end else begin
        o_min_x <= '0;
        o_max_x <= '0;
        o_min_y <= '0;
        o_max_y <= '0;
      end
    end
    if (accept) begin
      o_point_valid <= 1'b0;
      o_point       <= '0;
    end else if ((state == spi_pkg::ST_LOAD) && hit_valid && o_is_read) begin
      o_point_valid <= 1'b1;
      o_point       <= rd[TABLE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_is_read <= is_read;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    o_valid    = 1'b0;
    unique case (state)
      spi_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = is_read ? spi_pkg::ST_WALK : spi_pkg::ST_LOAD;
        end
      end
      spi_pkg::ST_WALK: begin
        if (walk_cnt == WW'(TABLE_DEPTH - 1)) begin
          state_next = spi_pkg::ST_LOAD;
        end
      end
      spi_pkg::ST_LOAD: begin
        state_next = spi_pkg::ST_OUT;
      end
      spi_pkg::ST_OUT: begin
        o_valid = 1'b1;
        if (rsp.ready) begin
          state_next = spi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spi_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp.valid          = o_valid;
  assign rsp.point_valid    = o_point_valid;
  assign rsp.point_x        = o_point.x;
  assign rsp.point_y        = o_point.y;
  assign rsp.point_rgb      = o_point.rgb;
  assign rsp.point_tag      = o_point.tag;
  assign rsp.entry_count    = o_count;
  assign rsp.min_x          = o_min_x;
  assign rsp.max_x          = o_max_x;
  assign rsp.min_y          = o_min_y;
  assign rsp.max_y          = o_max_y;
  assign rsp.insert_dropped = o_dropped;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= TABLE_DEPTH)
    else $error("count above table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow count");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.insert_dropped) |-> full)
    else $error("drop flagged with room left");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("input taken while a result waits");

endmodule

`default_nettype wire

[sim/tb_sorted_point_insert_table_unit.sv]
`timescale 1ns / 1ps

module tb_sorted_point_insert_table_unit;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_TAIL = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = DEPTH + 10;
  localparam logic [spi_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [spi_pkg::MODE_W-1:0]          mode;
    logic signed [spi_pkg::COORD_W-1:0]  x;
    logic signed [spi_pkg::COORD_W-1:0]  y;
    logic [spi_pkg::RGB_W-1:0]           rgb;
    logic [spi_pkg::TAG_W-1:0]           tag;
    logic [spi_pkg::INDEX_W-1:0]         idx;
  } point_req_t;

  typedef struct packed {
    logic                                pv;
    spi_pkg::point_t                     pt;
    logic [spi_pkg::COUNT_W-1:0]         count;
    logic signed [spi_pkg::COORD_W-1:0]  lo_x;
    logic signed [spi_pkg::COORD_W-1:0]  hi_x;
    logic signed [spi_pkg::COORD_W-1:0]  lo_y;
    logic [spi_pkg::MAX_Y_W-1:0]         hi_y;
    logic                                dropped;
  } table_status_t;

  typedef struct {
    point_req_t    item;
    bit            typed;
    table_status_t want;
  } dir_row_t;

  localparam table_status_t EMPTY_STATUS = '0;
  localparam table_status_t FIRST_INSERT = '{pv: 1'b0, pt: '0, count: 7'd1,
                                             lo_x: 32'h7fffffff, hi_x: 32'h7fffffff,
                                             lo_y: 32'h80000000, hi_y: '0, dropped: 1'b0};

  logic clk = 1'b0;
  logic rst;

  spi_in_if  point_req ();
  spi_out_if point_rsp ();

  sorted_point_insert_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (point_req),
    .rsp (point_rsp)
  );

  always #1 clk = ~clk;

  // shadow copy of the sorted table
  spi_pkg::point_t    shadow_pts [DEPTH];
  int                 shadow_held;
  logic signed [31:0] shadow_low_y;
  logic [30:0]        shadow_high_y;

  table_status_t expected_status_q [$];
  table_status_t oldest_status;
  dir_row_t      dir_rows [$];

  int  failures;
  int  items_sent;
  int  results_checked;
  int  idle_cycles;
  int  n_insert, n_dropped, n_read_hit, n_read_miss, n_clear, n_unused;
  bit  no_gaps;

  function automatic table_status_t predict_table_status(point_req_t it);
    table_status_t r;
    int pos;
    int k;
    r = '0;
    case (it.mode)
      spi_pkg::MODE_INSERT: begin
        if (shadow_held >= DEPTH) begin
          r.dropped = 1'b1;
          n_dropped++;
        end else begin
          pos = 0;
          while (pos < shadow_held && !(shadow_pts[pos].x > it.x)) pos++;
          for (k = shadow_held; k > pos; k--) shadow_pts[k] = shadow_pts[k-1];
          shadow_pts[pos].x = it.x;
          shadow_pts[pos].y = it.y;
          shadow_pts[pos].rgb = it.rgb;
          shadow_pts[pos].tag = it.tag;
          if (shadow_held == 0 || shadow_low_y > it.y) shadow_low_y = it.y;
          if (!it.y[31] && it.y[30:0] > shadow_high_y) shadow_high_y = it.y[30:0];
          shadow_held++;
        end
        n_insert++;
      end
      spi_pkg::MODE_CLEAR: begin
        shadow_held = 0;
        shadow_low_y = '0;
        shadow_high_y = '0;
        n_clear++;
      end
      spi_pkg::MODE_READ: begin
        if (int'(it.idx) < shadow_held) begin
          r.pv = 1'b1;
          r.pt = shadow_pts[it.idx];
          n_read_hit++;
        end else begin
          n_read_miss++;
        end
      end
      default: n_unused++;
    endcase
    r.count = spi_pkg::COUNT_W'(shadow_held);
    if (shadow_held > 0) begin
      r.lo_x = shadow_pts[0].x;
      r.hi_x = shadow_pts[shadow_held-1].x;
      r.lo_y = shadow_low_y;
      r.hi_y = shadow_high_y;
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [spi_pkg::MODE_W-1:0] mode, logic [31:0] x,
                                       logic [31:0] y, logic [23:0] rgb, logic [15:0] tag,
                                       logic [5:0] idx, bit typed, table_status_t want);
    dir_row_t row;
    row.item.mode = mode;
    row.item.x = x;
    row.item.y = y;
    row.item.rgb = rgb;
    row.item.tag = tag;
    row.item.idx = idx;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic point_req_t random_item(logic [spi_pkg::MODE_W-1:0] mode);
    point_req_t it;
    it.mode = mode;
    case ($urandom_range(0, 9))
      0:       it.x = 32'h80000000;
      1:       it.x = 32'h7fffffff;
      2, 3, 4: it.x = {16'(int'($urandom_range(0, 4)) - 2), 16'h0000};
      default: it.x = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       it.y = 32'h80000000;
      1:       it.y = 32'h7fffffff;
      2:       it.y = {16'(int'($urandom_range(0, 4)) - 2), 16'h0000};
      default: it.y = $urandom;
    endcase
    it.rgb = spi_pkg::RGB_W'($urandom_range(0, 24'hffffff));
    it.tag = spi_pkg::TAG_W'($urandom_range(0, 16'hffff));
    if (mode == spi_pkg::MODE_READ && shadow_held > 0 && $urandom_range(0, 3) != 0)
      it.idx = spi_pkg::INDEX_W'($urandom_range(0, shadow_held - 1));
    else
      it.idx = spi_pkg::INDEX_W'($urandom_range(0, 63));
    return it;
  endfunction

  task automatic send_item(point_req_t it, bit typed, table_status_t want);
    table_status_t predicted;
    @(negedge clk);
    point_req.valid <= 1'b1;
    point_req.mode <= it.mode;
    point_req.x_value <= it.x;
    point_req.y_value <= it.y;
    point_req.point_color <= it.rgb;
    point_req.name_tag <= it.tag;
    point_req.read_index <= it.idx;
    do @(posedge clk); while (!point_req.ready);
    predicted = predict_table_status(it);
    expected_status_q.push_back(typed ? want : predicted);
    items_sent++;
    no_gaps = items_sent >= dir_rows.size() + RANDOM_ITEMS - QUIET_TAIL;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      point_req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    point_req.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_random();
    int episode;
    int goal;
    int n;
    int pick;
    episode = 0;
    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      if (episode == 0 || (!no_gaps && $urandom_range(0, 3) == 0)) drain_results();
      if ($urandom_range(0, 7) != 0)
        send_item(random_item(spi_pkg::MODE_CLEAR), 1'b0, '0);
      goal = (episode == 1 || episode == 4) ? DEPTH + 3 : $urandom_range(1, 14);
      for (n = 0; n < goal; n++) begin
        send_item(random_item(spi_pkg::MODE_INSERT), 1'b0, '0);
        pick = $urandom_range(0, 29);
        if (pick < 9) send_item(random_item(spi_pkg::MODE_READ), 1'b0, '0);
        else if (pick == 9) send_item(random_item(MODE_UNUSED), 1'b0, '0);
        else if (pick == 10 && goal <= DEPTH)
          send_item(random_item(spi_pkg::MODE_CLEAR), 1'b0, '0);
      end
      repeat ($urandom_range(1, 4)) send_item(random_item(spi_pkg::MODE_READ), 1'b0, '0);
      episode++;
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && point_rsp.valid && point_rsp.ready) begin
      if (expected_status_q.size() == 0) begin
        $error("result item with nothing pending");
        failures++;
      end else begin
        oldest_status = expected_status_q.pop_front();
        results_checked++;
        check_field("point_valid", oldest_status.pv, point_rsp.point_valid);
        check_field("point_x", oldest_status.pt.x, point_rsp.point_x);
        check_field("point_y", oldest_status.pt.y, point_rsp.point_y);
        check_field("point_rgb", oldest_status.pt.rgb, point_rsp.point_rgb);
        check_field("point_tag", oldest_status.pt.tag, point_rsp.point_tag);
        check_field("entry_count", oldest_status.count, point_rsp.entry_count);
        check_field("min_x", oldest_status.lo_x, point_rsp.min_x);
        check_field("max_x", oldest_status.hi_x, point_rsp.max_x);
        check_field("min_y", oldest_status.lo_y, point_rsp.min_y);
        check_field("max_y", oldest_status.hi_y, point_rsp.max_y);
        check_field("insert_dropped", oldest_status.dropped, point_rsp.insert_dropped);
      end
    end
  end

  always @(posedge clk) begin
    if ((point_req.valid && point_req.ready) || (point_rsp.valid && point_rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    point_rsp.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (no_gaps) begin
        @(negedge clk);
        point_rsp.ready <= 1'b1;
      end else begin
        repeat ($urandom_range(1, 40)) begin
          @(negedge clk);
          point_rsp.ready <= 1'b1;
        end
        repeat ($urandom_range(1, 10)) begin
          @(negedge clk);
          point_rsp.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    point_req.valid = 1'b0;
    point_req.mode = spi_pkg::MODE_INSERT;
    point_req.x_value = '0;
    point_req.y_value = '0;
    point_req.point_color = '0;
    point_req.name_tag = '0;
    point_req.read_index = '0;
    failures = 0;
    items_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    {n_insert, n_dropped, n_read_hit, n_read_miss, n_clear, n_unused} = '0;
    no_gaps = 1'b0;
    shadow_held = 0;
    shadow_low_y = '0;
    shadow_high_y = '0;

    dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 0, 1'b1, EMPTY_STATUS));
    dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 63, 1'b1, EMPTY_STATUS));
    dir_rows.push_back(dir_row(MODE_UNUSED, 32'hffffffff, 32'hffffffff, 24'hffffff,
                               16'hffff, 63, 1'b1, EMPTY_STATUS));
    dir_rows.push_back(dir_row(spi_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 1'b1, EMPTY_STATUS));
    dir_rows.push_back(dir_row(spi_pkg::MODE_INSERT, 32'h7fffffff, 32'h80000000, 24'hffffff,
                               16'hffff, 0, 1'b1, FIRST_INSERT));
    dir_rows.push_back(dir_row(spi_pkg::MODE_INSERT, 32'h80000000, 32'h7fffffff, 0, 0, 0,
                               1'b0, '0));
    dir_rows.push_back(dir_row(spi_pkg::MODE_INSERT, 0, 0, 24'h5a5a5a, 16'h1234, 0,
                               1'b0, '0));
    // equal x keeps arrival order
    dir_rows.push_back(dir_row(spi_pkg::MODE_INSERT, 0, 32'hffffffff, 24'ha5a5a5, 16'h4321, 0,
                               1'b0, '0));
    dir_rows.push_back(dir_row(spi_pkg::MODE_INSERT, 32'h00010000, 32'h00008000, 24'h123456,
                               16'hbeef, 0, 1'b0, '0));
    for (int i = 0; i < 5; i++)
      dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 6'(i), 1'b0, '0));
    dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 5, 1'b0, '0));
    dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 32'hffffffff, 32'hffffffff, 24'hffffff,
                               16'hffff, 63, 1'b0, '0));
    dir_rows.push_back(dir_row(MODE_UNUSED, 32'hffffffff, 32'hffffffff, 24'hffffff,
                               16'hffff, 2, 1'b0, '0));
    dir_rows.push_back(dir_row(spi_pkg::MODE_CLEAR, 32'hffffffff, 32'hffffffff, 24'hffffff,
                               16'hffff, 63, 1'b1, EMPTY_STATUS));
    dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 0, 1'b1, EMPTY_STATUS));
    dir_rows.push_back(dir_row(spi_pkg::MODE_INSERT, 32'hffffffff, 32'hfffb0000, 24'h00ff00,
                               16'h0001, 0, 1'b0, '0));
    dir_rows.push_back(dir_row(spi_pkg::MODE_READ, 0, 0, 0, 0, 0, 1'b0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    run_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d refused on a full table), %0d reads (%0d past count)",
             n_insert, n_dropped, n_read_hit + n_read_miss, n_read_miss);
    $display("plus %0d clears and %0d unused-mode items; %0d results checked",
             n_clear, n_unused, results_checked);
    if (failures == 0 && expected_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
